// ----- rtl/core/lfuct_pkg.sv -----
// ----------------------------------------------------------------------------
// LFU cache table package
// Field widths, command codes and default sizes shared by the cache table.
// ----------------------------------------------------------------------------
package lfuct_pkg;

   localparam int KEY_BITS       = 32;
   localparam int VALUE_BITS     = 32;
   localparam int CAP_BITS       = 5;
   localparam int REQ_DATA_BITS  = KEY_BITS + VALUE_BITS;
   localparam int RSP_DATA_BITS  = VALUE_BITS + KEY_BITS;
   localparam int RSP_USER_BITS  = 2;

   localparam int DEF_ENTRIES    = 16;
   localparam int DEF_COUNT_BITS = 16;

   localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(16);

   localparam logic CMD_GET = 1'b0;
   localparam logic CMD_PUT = 1'b1;

endpackage

// ----- rtl/core/lfu_cache_table.sv -----
// ----------------------------------------------------------------------------
// LFU cache table
// Key-value store with least-frequently-used replacement and LRU tie-break.
// ----------------------------------------------------------------------------
// Each request word is a get or a put and yields exactly one response word.
// A request is handled in two passes over the entry table through a single
// RAM read port: a scan pass that matches the key and picks the victim, and
// an update pass that closes the recency rank and writes the touched entry.
// A word that writes the table runs both passes; a get that misses skips
// the update pass and moves on from the decision to its response.
// A finished response waits in its own register, so the next request is
// accepted while it is pending; a further response that cannot leave holds
// the block in its last step until that register frees.
module lfu_cache_table #(
   parameter int ENTRIES    = lfuct_pkg::DEF_ENTRIES,
   parameter int COUNT_BITS = lfuct_pkg::DEF_COUNT_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [lfuct_pkg::CAP_BITS-1:0]    csr_wdata,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // lookup_key, write_value
   input  logic [lfuct_pkg::REQ_DATA_BITS-1:0] req_tdata,
   // cmd
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // read_value, evicted_key
   output logic [lfuct_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   // hit, evicted
   output logic [lfuct_pkg::RSP_USER_BITS-1:0] rsp_tuser
);

   import lfuct_pkg::*;

   localparam int IDX_BITS  = $clog2(ENTRIES);
   localparam int PTR_BITS  = IDX_BITS + 1;
   localparam int META_BITS = COUNT_BITS + IDX_BITS;
   localparam int EW        = (PTR_BITS > CAP_BITS) ? PTR_BITS : CAP_BITS;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_DECIDE = 3'd2;
   localparam logic [2:0] ST_UPDATE = 3'd3;
   localparam logic [2:0] ST_DONE   = 3'd4;

   logic [2:0]            state_ff, state_in;
   logic [CAP_BITS-1:0]   cap_ff, cap_in;
   logic                  cmd_ff, cmd_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [VALUE_BITS-1:0] wval_ff, wval_in;
   logic [PTR_BITS-1:0]   ptr_ff, ptr_in;
   logic                  chk_vld_ff, chk_vld_in;
   logic [IDX_BITS-1:0]   chk_idx_ff, chk_idx_in;
   logic [ENTRIES-1:0]    valid_ff, valid_in;
   logic [PTR_BITS-1:0]   used_ff, used_in;

   logic                  found_ff, found_in;
   logic [IDX_BITS-1:0]   slot_ff, slot_in;
   logic [COUNT_BITS-1:0] slot_cnt_ff, slot_cnt_in;
   logic [IDX_BITS-1:0]   slot_rec_ff, slot_rec_in;
   logic                  free_ok_ff, free_ok_in;
   logic [IDX_BITS-1:0]   free_slot_ff, free_slot_in;
   logic                  vic_ok_ff, vic_ok_in;
   logic [IDX_BITS-1:0]   vic_ff, vic_in;
   logic [COUNT_BITS-1:0] vic_cnt_ff, vic_cnt_in;
   logic [IDX_BITS-1:0]   vic_rec_ff, vic_rec_in;
   logic [KEY_BITS-1:0]   vic_key_ff, vic_key_in;

   logic [IDX_BITS-1:0]   target_ff, target_in;
   logic                  close_en_ff, close_en_in;
   logic [IDX_BITS-1:0]   close_rank_ff, close_rank_in;
   logic [COUNT_BITS-1:0] new_cnt_ff, new_cnt_in;
   logic [IDX_BITS-1:0]   new_rec_ff, new_rec_in;
   logic                  res_hit_ff, res_hit_in;
   logic                  res_ev_ff, res_ev_in;
   logic [KEY_BITS-1:0]   res_evk_ff, res_evk_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_hit_ff, rsp_hit_in;
   logic                  rsp_ev_ff, rsp_ev_in;
   logic [VALUE_BITS-1:0] rsp_rval_ff, rsp_rval_in;
   logic [KEY_BITS-1:0]   rsp_evk_ff, rsp_evk_in;

   logic                  key_wr_en, key_rd_en;
   logic [IDX_BITS-1:0]   key_wr_addr, key_rd_addr;
   logic [KEY_BITS-1:0]   key_rd_data;
   logic                  val_wr_en, val_rd_en;
   logic [IDX_BITS-1:0]   val_wr_addr, val_rd_addr;
   logic [VALUE_BITS-1:0] val_rd_data;
   logic                  meta_wr_en, meta_rd_en;
   logic [IDX_BITS-1:0]   meta_wr_addr, meta_rd_addr;
   logic [META_BITS-1:0]  meta_wr_data, meta_rd_data;

   logic [COUNT_BITS-1:0] m_cnt;
   logic [IDX_BITS-1:0]   m_rec;
   logic                  ent_vld;
   logic                  issue;
   logic                  last_chk;
   logic [EW-1:0]         cap_ext, used_ext, eff_cap;
   logic                  evict;
   logic [IDX_BITS-1:0]   tgt;
   logic                  rsp_free;

   lfuct_ram #(.WIDTH(KEY_BITS), .DEPTH(ENTRIES)) u_key_ram (
      .clock   (clock),
      .wr_en   (key_wr_en),
      .wr_addr (key_wr_addr),
      .wr_data (key_ff),
      .rd_en   (key_rd_en),
      .rd_addr (key_rd_addr),
      .rd_data (key_rd_data)
   );

   lfuct_ram #(.WIDTH(VALUE_BITS), .DEPTH(ENTRIES)) u_val_ram (
      .clock   (clock),
      .wr_en   (val_wr_en),
      .wr_addr (val_wr_addr),
      .wr_data (wval_ff),
      .rd_en   (val_rd_en),
      .rd_addr (val_rd_addr),
      .rd_data (val_rd_data)
   );

   lfuct_ram #(.WIDTH(META_BITS), .DEPTH(ENTRIES)) u_meta_ram (
      .clock   (clock),
      .wr_en   (meta_wr_en),
      .wr_addr (meta_wr_addr),
      .wr_data (meta_wr_data),
      .rd_en   (meta_rd_en),
      .rd_addr (meta_rd_addr),
      .rd_data (meta_rd_data)
   );

   assign m_cnt    = meta_rd_data[IDX_BITS +: COUNT_BITS];
   assign m_rec    = meta_rd_data[IDX_BITS-1:0];
   assign ent_vld  = valid_ff[chk_idx_ff];
   assign last_chk = chk_vld_ff && (chk_idx_ff == IDX_BITS'(ENTRIES - 1));
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   // A capacity of zero acts as one, and one above the table size as the size.
   assign cap_ext  = EW'(cap_ff);
   assign used_ext = EW'(used_ff);
   assign eff_cap  = (cap_ext == '0) ? EW'(1) :
                     (cap_ext > EW'(ENTRIES)) ? EW'(ENTRIES) : cap_ext;
   assign evict    = !found_ff && (cmd_ff == CMD_PUT) && (used_ext >= eff_cap);
   assign tgt      = found_ff ? slot_ff : (evict ? vic_ff : free_slot_ff);

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_evk_ff, rsp_rval_ff};
   assign rsp_tuser  = {rsp_ev_ff, rsp_hit_ff};

   always_comb begin
      state_in      = state_ff;
      cap_in        = csr_we ? csr_wdata : cap_ff;
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      wval_in       = wval_ff;
      ptr_in        = ptr_ff;
      chk_vld_in    = 1'b0;
      chk_idx_in    = chk_idx_ff;
      valid_in      = valid_ff;
      used_in       = used_ff;
      found_in      = found_ff;
      slot_in       = slot_ff;
      slot_cnt_in   = slot_cnt_ff;
      slot_rec_in   = slot_rec_ff;
      free_ok_in    = free_ok_ff;
      free_slot_in  = free_slot_ff;
      vic_ok_in     = vic_ok_ff;
      vic_in        = vic_ff;
      vic_cnt_in    = vic_cnt_ff;
      vic_rec_in    = vic_rec_ff;
      vic_key_in    = vic_key_ff;
      target_in     = target_ff;
      close_en_in   = close_en_ff;
      close_rank_in = close_rank_ff;
      new_cnt_in    = new_cnt_ff;
      new_rec_in    = new_rec_ff;
      res_hit_in    = res_hit_ff;
      res_ev_in     = res_ev_ff;
      res_evk_in    = res_evk_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_hit_in    = rsp_hit_ff;
      rsp_ev_in     = rsp_ev_ff;
      rsp_rval_in   = rsp_rval_ff;
      rsp_evk_in    = rsp_evk_ff;

      issue         = ptr_ff < PTR_BITS'(ENTRIES);
      key_rd_en     = 1'b0;
      key_rd_addr   = ptr_ff[IDX_BITS-1:0];
      key_wr_en     = 1'b0;
      key_wr_addr   = tgt;
      val_rd_en     = 1'b0;
      val_rd_addr   = tgt;
      val_wr_en     = 1'b0;
      val_wr_addr   = tgt;
      meta_rd_en    = 1'b0;
      meta_rd_addr  = ptr_ff[IDX_BITS-1:0];
      meta_wr_en    = 1'b0;
      meta_wr_addr  = chk_idx_ff;
      meta_wr_data  = meta_rd_data;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd_in     = req_tuser;
               key_in     = req_tdata[KEY_BITS-1:0];
               wval_in    = req_tdata[KEY_BITS +: VALUE_BITS];
               ptr_in     = '0;
               found_in   = 1'b0;
               free_ok_in = 1'b0;
               vic_ok_in  = 1'b0;
               state_in   = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (issue) begin
               key_rd_en  = 1'b1;
               meta_rd_en = 1'b1;
               ptr_in     = ptr_ff + PTR_BITS'(1);
               chk_vld_in = 1'b1;
               chk_idx_in = ptr_ff[IDX_BITS-1:0];
            end
            if (chk_vld_ff) begin
               if (!found_ff && ent_vld && (key_rd_data == key_ff)) begin
                  found_in    = 1'b1;
                  slot_in     = chk_idx_ff;
                  slot_cnt_in = m_cnt;
                  slot_rec_in = m_rec;
               end
               if (!free_ok_ff && !ent_vld) begin
                  free_ok_in   = 1'b1;
                  free_slot_in = chk_idx_ff;
               end
               if (ent_vld && (!vic_ok_ff || (m_cnt < vic_cnt_ff) ||
                               ((m_cnt == vic_cnt_ff) && (m_rec < vic_rec_ff)))) begin
                  vic_ok_in  = 1'b1;
                  vic_in     = chk_idx_ff;
                  vic_cnt_in = m_cnt;
                  vic_rec_in = m_rec;
                  vic_key_in = key_rd_data;
               end
            end
            if (last_chk) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            target_in  = tgt;
            ptr_in     = '0;
            res_hit_in = found_ff;
            res_ev_in  = evict;
            res_evk_in = evict ? vic_key_ff : '0;
            if (found_ff) begin
               close_en_in   = 1'b1;
               close_rank_in = slot_rec_ff;
               new_cnt_in    = (&slot_cnt_ff) ? slot_cnt_ff : slot_cnt_ff + COUNT_BITS'(1);
               new_rec_in    = IDX_BITS'(used_ff - PTR_BITS'(1));
               val_rd_en     = (cmd_ff == CMD_GET);
               val_wr_en     = (cmd_ff == CMD_PUT);
               state_in      = ST_UPDATE;
            end else if (cmd_ff == CMD_PUT) begin
               key_wr_en  = 1'b1;
               val_wr_en  = 1'b1;
               new_cnt_in = COUNT_BITS'(1);
               if (evict) begin
                  close_en_in   = 1'b1;
                  close_rank_in = vic_rec_ff;
                  new_rec_in    = IDX_BITS'(used_ff - PTR_BITS'(1));
               end else begin
                  close_en_in   = 1'b0;
                  new_rec_in    = IDX_BITS'(used_ff);
                  valid_in[tgt] = 1'b1;
                  used_in       = used_ff + PTR_BITS'(1);
               end
               state_in = ST_UPDATE;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_UPDATE: begin
            if (issue) begin
               meta_rd_en = 1'b1;
               ptr_in     = ptr_ff + PTR_BITS'(1);
               chk_vld_in = 1'b1;
               chk_idx_in = ptr_ff[IDX_BITS-1:0];
            end
            if (chk_vld_ff) begin
               meta_wr_en = 1'b1;
               if (chk_idx_ff == target_ff) begin
                  meta_wr_data = {new_cnt_ff, new_rec_ff};
               end else if (close_en_ff && ent_vld && (m_rec > close_rank_ff)) begin
                  meta_wr_data = {m_cnt, m_rec - IDX_BITS'(1)};
               end
            end
            if (last_chk) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = res_hit_ff;
               rsp_ev_in    = res_ev_ff;
               rsp_evk_in   = res_evk_ff;
               rsp_rval_in  = (res_hit_ff && (cmd_ff == CMD_GET)) ? val_rd_data : '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cap_ff       <= CAP_RESET;
         chk_vld_ff   <= 1'b0;
         valid_ff     <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         chk_vld_ff   <= chk_vld_in;
         valid_ff     <= valid_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      wval_ff       <= wval_in;
      ptr_ff        <= ptr_in;
      chk_idx_ff    <= chk_idx_in;
      found_ff      <= found_in;
      slot_ff       <= slot_in;
      slot_cnt_ff   <= slot_cnt_in;
      slot_rec_ff   <= slot_rec_in;
      free_ok_ff    <= free_ok_in;
      free_slot_ff  <= free_slot_in;
      vic_ok_ff     <= vic_ok_in;
      vic_ff        <= vic_in;
      vic_cnt_ff    <= vic_cnt_in;
      vic_rec_ff    <= vic_rec_in;
      vic_key_ff    <= vic_key_in;
      target_ff     <= target_in;
      close_en_ff   <= close_en_in;
      close_rank_ff <= close_rank_in;
      new_cnt_ff    <= new_cnt_in;
      new_rec_ff    <= new_rec_in;
      res_hit_ff    <= res_hit_in;
      res_ev_ff     <= res_ev_in;
      res_evk_ff    <= res_evk_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_ev_ff     <= rsp_ev_in;
      rsp_rval_ff   <= rsp_rval_in;
      rsp_evk_ff    <= rsp_evk_in;
   end

endmodule

// ----- rtl/core/lfuct_ram.sv -----
// ----------------------------------------------------------------------------
// LFU cache table RAM
// Generic simple dual-port RAM with one write port and one registered read.
// ----------------------------------------------------------------------------
module lfuct_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- bench/tb_lfu_cache_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LFU cache table testbench
// Sends get and put words over the request stream and checks every response
// word against an in-bench copy of the table that tracks use counts, recency
// ranks and the capacity register. Covers key and value extremes, capacity
// limits, a capacity lowered below the fill level, long response stalls and
// randomized traffic over small key pools with random idle gaps.
// ----------------------------------------------------------------------------
module tb_lfu_cache_table;
   import lfuct_pkg::*;

   localparam int ENTRIES      = DEF_ENTRIES;
   localparam int COUNT_BITS   = DEF_COUNT_BITS;
   localparam int SETTLE_CYCLES = 2 * ENTRIES + 8;

   typedef struct {
      logic                  hit;
      logic [VALUE_BITS-1:0] read_value;
      logic                  evicted;
      logic [KEY_BITS-1:0]   evicted_key;
   } reply_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       csr_we = 1'b0;
   logic [CAP_BITS-1:0]        csr_wdata = '0;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [REQ_DATA_BITS-1:0]   req_tdata = '0;
   logic                       req_tuser = CMD_GET;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0]   rsp_tdata;
   logic [RSP_USER_BITS-1:0]   rsp_tuser;

   // Shadow copy of the table.
   logic [KEY_BITS-1:0]   slot_key   [ENTRIES];
   logic [VALUE_BITS-1:0] slot_value [ENTRIES];
   logic [COUNT_BITS-1:0] slot_uses  [ENTRIES];
   int                    slot_rank  [ENTRIES];
   bit                    slot_live  [ENTRIES];
   int                    live_count = 0;
   logic [CAP_BITS-1:0]   capacity_reg = CAP_RESET;

   reply_type           expected_replies[$];
   logic [KEY_BITS-1:0] key_pool[$];
   int                  mismatches = 0;
   bit                  sender_gaps_on = 1'b1;
   bit                  receiver_stalls_on = 1'b1;
   int                  hold_request = 0;
   int                  stall_left = 0;

   lfu_cache_table #(
      .ENTRIES    (ENTRIES),
      .COUNT_BITS (COUNT_BITS)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // lookup_key, write_value
      .req_tuser  (req_tuser),   // cmd
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // read_value, evicted_key
      .rsp_tuser  (rsp_tuser)    // hit, evicted
   );

   always #5 clock = ~clock;

   initial begin
      #(64'd10_000_000);
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic void close_rank(int rank);
      for (int j = 0; j < ENTRIES; j++)
         if (slot_live[j] && slot_rank[j] > rank) slot_rank[j]--;
   endfunction

   // Applies one operation to the shadow table and returns the response word.
   function automatic reply_type cache_access(logic cmd, logic [KEY_BITS-1:0] key,
                                              logic [VALUE_BITS-1:0] value);
      reply_type r;
      int        slot;
      int        victim;
      int        limit;
      r.hit = 1'b0;
      r.read_value = '0;
      r.evicted = 1'b0;
      r.evicted_key = '0;
      slot = -1;
      victim = -1;
      limit = (capacity_reg == 0) ? 1 :
              ((int'(capacity_reg) > ENTRIES) ? ENTRIES : int'(capacity_reg));
      for (int i = 0; i < ENTRIES; i++)
         if (slot < 0 && slot_live[i] && slot_key[i] == key) slot = i;
      if (slot >= 0) begin
         r.hit = 1'b1;
         if (cmd == CMD_GET) r.read_value = slot_value[slot];
         else slot_value[slot] = value;
         close_rank(slot_rank[slot]);
         slot_rank[slot] = live_count - 1;
         if (slot_uses[slot] != '1) slot_uses[slot]++;
      end else if (cmd == CMD_PUT) begin
         if (live_count >= limit) begin
            for (int i = 0; i < ENTRIES; i++) begin
               if (slot_live[i] && (victim < 0 || slot_uses[i] < slot_uses[victim] ||
                   (slot_uses[i] == slot_uses[victim] && slot_rank[i] < slot_rank[victim])))
                  victim = i;
            end
            r.evicted = 1'b1;
            r.evicted_key = slot_key[victim];
            close_rank(slot_rank[victim]);
            slot_live[victim] = 1'b0;
            live_count--;
            slot = victim;
         end else begin
            for (int i = 0; i < ENTRIES; i++)
               if (slot < 0 && !slot_live[i]) slot = i;
         end
         slot_live[slot] = 1'b1;
         slot_key[slot] = key;
         slot_value[slot] = value;
         slot_uses[slot] = COUNT_BITS'(1);
         live_count++;
         slot_rank[slot] = live_count - 1;
      end
      return r;
   endfunction

   function automatic int random_pause();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return $urandom_range(1, 3);
      if (roll < 95) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Response side: checks each word and decides the next ready level.
   always @(posedge clock) begin
      reply_type got;
      reply_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.read_value = rsp_tdata[VALUE_BITS-1:0];
         got.evicted_key = rsp_tdata[VALUE_BITS +: KEY_BITS];
         got.hit = rsp_tuser[0];
         got.evicted = rsp_tuser[1];
         if (expected_replies.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected word, expected none, actual hit=%0d rd=%h ev=%0d evk=%h",
                     $time, got.hit, got.read_value, got.evicted, got.evicted_key);
         end else begin
            want = expected_replies.pop_front();
            if (got.hit !== want.hit || got.read_value !== want.read_value ||
                got.evicted !== want.evicted || got.evicted_key !== want.evicted_key) begin
               mismatches++;
               if (mismatches <= 40)
                  $display("%0t: expected hit=%0d rd=%h ev=%0d evk=%h, actual hit=%0d rd=%h ev=%0d evk=%h",
                           $time, want.hit, want.read_value, want.evicted, want.evicted_key,
                           got.hit, got.read_value, got.evicted, got.evicted_key);
            end
         end
      end
      if (hold_request > 0) begin
         stall_left = hold_request;
         hold_request = 0;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (receiver_stalls_on && $urandom_range(0, 99) < 30) begin
         stall_left = random_pause() - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic send_word(input logic cmd, input logic [KEY_BITS-1:0] key,
                            input logic [VALUE_BITS-1:0] value);
      int gap;
      gap = (sender_gaps_on && $urandom_range(0, 99) < 50) ? random_pause() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= {value, key};
      do @(posedge clock); while (!req_tready);
      expected_replies.push_back(cache_access(cmd, key, value));
   endtask

   task automatic stop_sending();
      if (req_tvalid) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic wait_for_replies();
      stop_sending();
      while (expected_replies.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_capacity(input logic [CAP_BITS-1:0] value);
      wait_for_replies();
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      capacity_reg = value;
   endtask

   task automatic test_key_extremes();
      send_word(CMD_GET, 32'h0000_0000, 32'h5555_5555);
      send_word(CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
      send_word(CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
      send_word(CMD_PUT, 32'h0000_0000, 32'h0000_0000);
      send_word(CMD_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_word(CMD_GET, 32'h8000_0000, 32'h0000_0000);
      send_word(CMD_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      send_word(CMD_PUT, 32'h0000_0000, 32'h1234_5678);
      send_word(CMD_GET, 32'h0000_0000, 32'h0000_0000);
      send_word(CMD_GET, 32'h0000_0001, 32'h0000_0000);
   endtask

   // The table holds more entries than the new capacity, so each new key
   // evicts exactly one entry and the fill level stays put.
   task automatic test_shrunk_capacity();
      set_capacity(CAP_BITS'(2));
      send_word(CMD_PUT, 32'h0000_0011, 32'hA5A5_A5A5);
      send_word(CMD_PUT, 32'h0000_0022, 32'h5A5A_5A5A);
      set_capacity(CAP_BITS'(0));
      send_word(CMD_PUT, 32'h0000_0033, 32'h0F0F_0F0F);
      send_word(CMD_GET, 32'h0000_0033, 32'h0000_0000);
   endtask

   task automatic test_capacity_above_table();
      set_capacity(CAP_BITS'(31));
      for (int i = 0; i < 12; i++)
         send_word(CMD_PUT, 32'h0000_1000 + i, $urandom());
   endtask

   task automatic test_backpressure();
      set_capacity(CAP_RESET);
      key_pool.delete();
      for (int i = 0; i < 8; i++) key_pool.push_back($urandom());
      hold_request = 300;
      for (int i = 0; i < 20; i++)
         send_word(1'($urandom_range(0, 1)), key_pool[$urandom_range(0, 7)], $urandom());
   endtask

   task automatic test_random_mix(input logic [CAP_BITS-1:0] capacity, input int words,
                                  input int pool_size, input bit quiet);
      logic [KEY_BITS-1:0] key;
      set_capacity(capacity);
      sender_gaps_on = !quiet;
      receiver_stalls_on = !quiet;
      key_pool.delete();
      for (int i = 0; i < pool_size; i++) key_pool.push_back($urandom());
      for (int i = 0; i < words; i++) begin
         key = ($urandom_range(0, 99) < 90) ? key_pool[$urandom_range(0, pool_size - 1)]
                                           : $urandom();
         send_word(($urandom_range(0, 99) < 45) ? CMD_PUT : CMD_GET, key, $urandom());
      end
      sender_gaps_on = 1'b1;
      receiver_stalls_on = 1'b1;
   endtask

   initial begin
      logic [CAP_BITS-1:0] mixed_capacity;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_key_extremes();
      test_shrunk_capacity();
      test_capacity_above_table();
      send_word(CMD_PUT, 32'h0000_2000, 32'hC3C3_C3C3);
      test_backpressure();
      test_random_mix(CAP_BITS'(16), 300, 24, 1'b0);
      test_random_mix(CAP_BITS'(1), 200, 4, 1'b0);
      test_random_mix(CAP_BITS'(31), 250, 28, 1'b0);
      test_random_mix(CAP_BITS'(5), 250, 9, 1'b0);
      test_random_mix(CAP_BITS'(0), 150, 3, 1'b0);
      mixed_capacity = CAP_BITS'($urandom_range(0, 31));
      test_random_mix(mixed_capacity, 200, 22, 1'b1);
      test_random_mix(CAP_BITS'(16), 154, 20, 1'b0);
      wait_for_replies();
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
